[design/adts_aac_frame_deframer_core_assert.svh]
// Assertion macros shared by the deframer RTL.
// ADTS_DFR_ASSERT_IMP: same-cycle implication, ADTS_DFR_ASSERT_NXT: next-cycle implication.
// Both sample on clk and are held off while rst_n is low.
`ifndef ADTS_AAC_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define ADTS_AAC_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define ADTS_DFR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adts deframer assertion failed");
`define ADTS_DFR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adts deframer assertion failed");
`else
`define ADTS_DFR_ASSERT_IMP(lbl, ante, cons)
`define ADTS_DFR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[design/adts_dfr_pkg.sv]
package adts_dfr_pkg;

  // Field and datapath widths
  localparam int RATE_W = 17;
  localparam int PTS_W  = 33;
  localparam int TIME_W = 63;
  localparam int IDX_W  = 16;
  localparam int TICK_W = 27;
  localparam int DVD_W  = TICK_W + IDX_W;
  localparam int DTS_W  = DVD_W + 1;

  // 90 kHz ticks in one 1024-sample frame, times the sample rate
  localparam logic [TICK_W-1:0] TICKS_PER_FRAME = TICK_W'(92160000);
  localparam logic [RATE_W-1:0] RATE_RESET      = RATE_W'(48000);

  typedef enum logic [1:0] {
    KIND_BYTE,
    KIND_END,
    KIND_ERR
  } kind_t;

  typedef enum logic [1:0] {
    FAULT_NONE,
    FAULT_HDR,
    FAULT_LEN,
    FAULT_TRUNC
  } fault_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             pes_start;
    logic             pes_end;
    logic [PTS_W-1:0] pes_pts;
  } in_item_t;

  typedef struct packed {
    kind_t             kind;
    logic [7:0]        payload;
    logic              frame_first;
    logic              frame_last;
    logic [TIME_W-1:0] frame_time;
    fault_t            fault;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[design/adts_dfr_div.sv]
module adts_dfr_div #(
  parameter int DVD_W = adts_dfr_pkg::DVD_W,
  parameter int DVS_W = adts_dfr_pkg::RATE_W
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [DVD_W-1:0]        dividend,
  input  logic [DVS_W-1:0]        divisor,
  output adts_dfr_pkg::div_stat_t stat,
  output logic [DVD_W-1:0]        quotient
);
  import adts_dfr_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVD_W-1:0] dq_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dq_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    ge    = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // load operands; a zero rate divides as one
        dq_r   <= dividend;
        rem_r  <= '0;
        dvs_r  <= (divisor == '0) ? DVS_W'(1) : divisor;
        cnt_r  <= CNT_W'(DVD_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        dq_r  <= {dq_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = dq_r;

endmodule

[design/adts_aac_frame_deframer_core.sv]
// A payload byte or error result is registered into out_* when it is free, else held in S_PUSH.
// A frame-closing byte goes through S_MUL, S_DIV, S_SUM and S_PUSH; in_ready is low meanwhile.
// Throughput: one byte per cycle while out_* is free, except that each frame-closing byte waits
// for the 43-step restoring divider that computes the frame time offset.
// Reset (rst_n low, synchronous): clears parser, timestamp unwrap state and output valid;
// the rate register returns to 48000.
`include "adts_aac_frame_deframer_core_assert.svh"

module adts_aac_frame_deframer_core (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  adts_dfr_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output adts_dfr_pkg::out_item_t out_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import adts_dfr_pkg::*;

  // Register index and header byte positions
  localparam logic       REG_RATE    = 1'b0;
  localparam logic [3:0] HDR_SYNC    = 4'd0;
  localparam logic [3:0] HDR_PROT    = 4'd1;
  localparam logic [3:0] HDR_LEN_HI  = 4'd3;
  localparam logic [3:0] HDR_LEN_MID = 4'd4;
  localparam logic [3:0] HDR_LEN_LO  = 4'd5;
  localparam logic [3:0] HDR_BASE    = 4'd7;
  localparam logic [3:0] HDR_CRC     = 4'd9;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SUM,
    S_PUSH
  } state_t;

  state_t            state_r, state_nxt;
  logic [RATE_W-1:0] rate_r;
  logic [3:0]        hc_r, hc_nxt;
  logic              crc_r, crc_nxt;
  logic [12:0]       len_r, len_nxt;
  logic [12:0]       left_r, left_nxt;
  logic              inpay_r, inpay_nxt;
  logic              drop_r, drop_nxt;
  logic [IDX_W-1:0]  fidx_r, fidx_nxt;
  logic [PTS_W-1:0]  pts_r, pts_nxt;
  logic              synced_r, synced_nxt;
  logic [PTS_W-1:0]  last_r, last_nxt;
  logic [TIME_W-1:0] run_r, run_nxt;
  logic [DTS_W-1:0]  dts_r, dts_nxt;
  out_item_t         pend_r, pend_nxt;
  out_item_t         out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Per-byte parse results
  logic [3:0]        st_hc;
  logic              st_crc;
  logic [12:0]       st_len;
  logic [12:0]       st_left;
  logic              st_inpay;
  logic              st_drop;
  logic [IDX_W-1:0]  st_fidx;
  logic [PTS_W-1:0]  st_pts;
  out_item_t         res;
  logic              res_vld;
  logic              res_close;

  logic              div_start;
  div_stat_t         div_st;
  logic [DVD_W-1:0]  div_q;
  logic [DVD_W-1:0]  frame_ticks;

  // Shared divider for the per-frame time offset
  adts_dfr_div #(
    .DVD_W(DVD_W),
    .DVS_W(RATE_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (frame_ticks),
    .divisor  (rate_r),
    .stat     (div_st),
    .quotient (div_q)
  );

  assign frame_ticks = DVD_W'(TICKS_PER_FRAME) * DVD_W'(fidx_r);

  // Parse one byte: header field capture, length checks, payload marks
  always_comb begin
    logic [3:0]  hc_inc;
    logic [3:0]  hl;
    logic [12:0] left_dec;
    st_hc     = hc_r;
    st_crc    = crc_r;
    st_len    = len_r;
    st_left   = left_r;
    st_inpay  = inpay_r;
    st_drop   = drop_r;
    st_fidx   = fidx_r;
    st_pts    = pts_r;
    res       = '0;
    res_vld   = 1'b0;
    res_close = 1'b0;
    hc_inc    = '0;
    left_dec  = '0;

    if (in_data.pes_start) begin
      st_hc    = '0;
      st_inpay = 1'b0;
      st_drop  = 1'b0;
      st_left  = '0;
      st_fidx  = '0;
      st_pts   = in_data.pes_pts;
    end

    hl = st_crc ? HDR_CRC : HDR_BASE;

    if (!st_drop) begin
      if (!st_inpay) begin
        case (st_hc)
          HDR_SYNC: begin
            st_crc = 1'b0;
            st_len = '0;
          end
          HDR_PROT:    st_crc = ~in_data.data_byte[0];
          HDR_LEN_HI:  st_len = {in_data.data_byte[1:0], st_len[10:0]};
          HDR_LEN_MID: st_len = {st_len[12:11], in_data.data_byte, st_len[2:0]};
          HDR_LEN_LO:  st_len = {st_len[12:3], in_data.data_byte[7:5]};
          default: ;
        endcase
        hc_inc = st_hc + 4'd1;
        hl     = st_crc ? HDR_CRC : HDR_BASE;
        if (hc_inc >= hl) begin
          st_hc = '0;
          if (st_len < {9'd0, hl}) begin
            // drop: length shorter than its own header
            res.kind  = KIND_ERR;
            res.fault = FAULT_LEN;
            res_vld   = 1'b1;
            st_drop   = 1'b1;
          end else if (st_len == {9'd0, hl}) begin
            res.kind       = KIND_END;
            res.frame_last = 1'b1;
            res_vld        = 1'b1;
            res_close      = 1'b1;
          end else begin
            st_left  = st_len - {9'd0, hl};
            st_inpay = 1'b1;
            if (in_data.pes_end) begin
              res.kind  = KIND_ERR;
              res.fault = FAULT_TRUNC;
              res_vld   = 1'b1;
              st_drop   = 1'b1;
            end
          end
        end else begin
          st_hc = hc_inc;
          if (in_data.pes_end) begin
            res.kind  = KIND_ERR;
            res.fault = FAULT_HDR;
            res_vld   = 1'b1;
            st_drop   = 1'b1;
          end
        end
      end else begin
        // pass a payload byte, mark first and last
        res.kind        = KIND_BYTE;
        res.payload     = in_data.data_byte;
        res.frame_first = (st_len >= {9'd0, hl}) && (st_left == st_len - {9'd0, hl});
        res_vld         = 1'b1;
        left_dec        = st_left - 13'd1;
        st_left         = left_dec;
        if (left_dec == '0) begin
          res.frame_last = 1'b1;
          res_close      = 1'b1;
          st_inpay       = 1'b0;
          st_hc          = '0;
        end else if (in_data.pes_end) begin
          res.fault = FAULT_TRUNC;
          st_drop   = 1'b1;
        end
      end
      if (in_data.pes_end) begin
        st_drop  = 1'b1;
        st_hc    = '0;
        st_inpay = 1'b0;
      end
    end
  end

  // Sequencer: accept, divide, unwrap, deliver
  always_comb begin
    logic [PTS_W-1:0] delta;
    logic [TIME_W:0]  sum;
    logic             out_free;
    state_nxt     = state_r;
    hc_nxt        = hc_r;
    crc_nxt       = crc_r;
    len_nxt       = len_r;
    left_nxt      = left_r;
    inpay_nxt     = inpay_r;
    drop_nxt      = drop_r;
    fidx_nxt      = fidx_r;
    pts_nxt       = pts_r;
    synced_nxt    = synced_r;
    last_nxt      = last_r;
    run_nxt       = run_r;
    dts_nxt       = dts_r;
    pend_nxt      = pend_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_free      = !out_valid_r || out_ready;
    div_start     = 1'b0;
    delta         = dts_r[PTS_W-1:0] - last_r;
    sum           = {1'b0, run_r} + (TIME_W + 1)'(delta);

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          hc_nxt    = st_hc;
          crc_nxt   = st_crc;
          len_nxt   = st_len;
          left_nxt  = st_left;
          inpay_nxt = st_inpay;
          drop_nxt  = st_drop;
          fidx_nxt  = st_fidx;
          pts_nxt   = st_pts;
          if (res_close) begin
            pend_nxt  = res;
            state_nxt = S_MUL;
          end else if (res_vld) begin
            if (out_free) begin
              out_nxt       = res;
              out_valid_nxt = 1'b1;
            end else begin
              pend_nxt  = res;
              state_nxt = S_PUSH;
            end
          end
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_st.done) begin
          dts_nxt   = DTS_W'(pts_r) + DTS_W'(div_q);
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        // unwrap over 33 bits and saturate the running time
        if (synced_r) begin
          run_nxt = sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
        end else begin
          run_nxt    = TIME_W'(dts_r);
          synced_nxt = 1'b1;
        end
        last_nxt            = dts_r[PTS_W-1:0];
        fidx_nxt            = fidx_r + IDX_W'(1);
        pend_nxt.frame_time = run_nxt;
        state_nxt           = S_PUSH;
      end
      S_PUSH: begin
        if (out_free) begin
          out_nxt       = pend_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hc_r        <= '0;
      crc_r       <= 1'b0;
      len_r       <= '0;
      left_r      <= '0;
      inpay_r     <= 1'b0;
      drop_r      <= 1'b0;
      fidx_r      <= '0;
      pts_r       <= '0;
      synced_r    <= 1'b0;
      last_r      <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hc_r        <= hc_nxt;
      crc_r       <= crc_nxt;
      len_r       <= len_nxt;
      left_r      <= left_nxt;
      inpay_r     <= inpay_nxt;
      drop_r      <= drop_nxt;
      fidx_r      <= fidx_nxt;
      pts_r       <= pts_nxt;
      synced_r    <= synced_nxt;
      last_r      <= last_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
      out_r       <= out_nxt;
      pend_r      <= pend_nxt;
      dts_r       <= dts_nxt;
    end
  end

  // Configuration register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_RATE)) begin
      rate_r <= pwdata[RATE_W-1:0];
    end
  end

  assign prdata    = (paddr[2] == REG_RATE) ? 32'(rate_r) : 32'd0;
  assign pready    = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `ADTS_DFR_ASSERT_IMP(a_ready_div_idle, in_ready, !div_st.busy)
  `ADTS_DFR_ASSERT_IMP(a_done_in_div, div_st.done, state_r == S_DIV)
  `ADTS_DFR_ASSERT_NXT(a_mul_starts_div, state_r == S_MUL, div_st.busy)
  `ADTS_DFR_ASSERT_IMP(a_drop_not_payload, drop_r, !inpay_r)
  `ADTS_DFR_ASSERT_IMP(a_err_has_fault, out_valid_r && out_r.kind == KIND_ERR,
                       !out_r.frame_last && out_r.fault != FAULT_NONE)

endmodule

[bench/adts_frame_checker.sv]
module adts_frame_checker #(
  parameter logic [2:0] RATE_ADDR = 3'd0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  adts_dfr_pkg::in_item_t  in_data,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  adts_dfr_pkg::out_item_t out_data,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic                    pready,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output int                      fails,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import adts_dfr_pkg::*;

  localparam logic [63:0] MASK33 = (64'd1 << 33) - 64'd1;
  localparam logic [63:0] MAX63  = (64'd1 << 63) - 64'd1;

  // Shadow of the block's parser and timestamp state
  logic [RATE_W-1:0] rate;
  logic [3:0]        hdr_cnt;
  logic              crc_on;
  logic [12:0]       flen;
  logic [12:0]       left;
  logic              in_body;
  logic              skip_pes;
  logic [IDX_W-1:0]  fidx;
  logic [PTS_W-1:0]  pes_time;
  logic              locked;
  logic [63:0]       prev_dts;
  logic [63:0]       run_time;
  int                errs;

  out_item_t awaited_out[$];

  initial begin
    errs    = 0;
  end

  // Advance the unwrapped timestamp for the frame that just closed
  function automatic logic [TIME_W-1:0] close_frame();
    logic [63:0] div;
    logic [63:0] dts;
    logic [63:0] delta;
    div = (rate == '0) ? 64'd1 : 64'(rate);
    dts = 64'(pes_time) + (64'(TICKS_PER_FRAME) * 64'(fidx)) / div;
    if (!locked) begin
      locked   = 1'b1;
      run_time = dts;
    end else begin
      delta    = (dts - prev_dts) & MASK33;
      run_time = (run_time > MAX63 - delta) ? MAX63 : run_time + delta;
    end
    prev_dts = dts;
    fidx     = fidx + 1'b1;
    return run_time[TIME_W-1:0];
  endfunction

  // Parse one request byte and queue the result it causes, if any
  function automatic void deframe_byte(in_item_t it);
    out_item_t r;
    logic      hit;
    int        hc;
    int        hl;
    r   = '0;
    hit = 1'b0;
    if (it.pes_start) begin
      hdr_cnt  = '0;
      in_body  = 1'b0;
      skip_pes = 1'b0;
      left     = '0;
      fidx     = '0;
      pes_time = it.pes_pts;
    end
    if (!skip_pes) begin
      if (!in_body) begin
        hc = int'(hdr_cnt);
        case (hc)
          0: begin
            crc_on = 1'b0;
            flen   = '0;
          end
          1: crc_on = ~it.data_byte[0];
          3: flen[12:11] = it.data_byte[1:0];
          4: flen[10:3] = it.data_byte;
          5: flen[2:0] = it.data_byte[7:5];
          default: ;
        endcase
        hc++;
        hdr_cnt = 4'(hc);
        hl = crc_on ? 9 : 7;
        if (hc >= hl) begin
          hdr_cnt = '0;
          if (flen < hl) begin
            r.kind   = KIND_ERR;
            r.fault  = FAULT_LEN;
            skip_pes = 1'b1;
            hit      = 1'b1;
          end else if (flen == hl) begin
            r.kind       = KIND_END;
            r.frame_last = 1'b1;
            r.frame_time = close_frame();
            hit          = 1'b1;
          end else begin
            left    = 13'(int'(flen) - hl);
            in_body = 1'b1;
            // Header done but the PES ends before any payload
            if (it.pes_end) begin
              r.kind   = KIND_ERR;
              r.fault  = FAULT_TRUNC;
              skip_pes = 1'b1;
              hit      = 1'b1;
            end
          end
        end else if (it.pes_end) begin
          r.kind   = KIND_ERR;
          r.fault  = FAULT_HDR;
          skip_pes = 1'b1;
          hit      = 1'b1;
        end
      end else begin
        hl = crc_on ? 9 : 7;
        r.kind        = KIND_BYTE;
        r.payload     = it.data_byte;
        r.frame_first = (flen >= hl) && (left == 13'(int'(flen) - hl));
        left          = left - 1'b1;
        if (left == '0) begin
          r.frame_last = 1'b1;
          r.frame_time = close_frame();
          in_body      = 1'b0;
          hdr_cnt      = '0;
        end else if (it.pes_end) begin
          r.fault  = FAULT_TRUNC;
          skip_pes = 1'b1;
        end
        hit = 1'b1;
      end
      if (it.pes_end) begin
        skip_pes = 1'b1;
        hdr_cnt  = '0;
        in_body  = 1'b0;
      end
    end
    if (hit) awaited_out.push_back(r);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      rate     = RATE_RESET;
      hdr_cnt  = '0;
      crc_on   = 1'b0;
      flen     = '0;
      left     = '0;
      in_body  = 1'b0;
      skip_pes = 1'b0;
      fidx     = '0;
      pes_time = '0;
      locked   = 1'b0;
      prev_dts = '0;
      run_time = '0;
      awaited_out.delete();
    end else begin
      // Track sample rate writes
      if (psel && penable && pwrite && pready && paddr == RATE_ADDR) begin
        rate = pwdata[RATE_W-1:0];
      end
      // Compare the result against the oldest expectation first
      if (out_valid && out_ready) begin
        if (awaited_out.size() == 0) begin
          $error("out_data: result with nothing expected");
          errs++;
        end else begin
          out_item_t e;
          e = awaited_out.pop_front();
          if (out_data.kind !== e.kind) begin
            $error("kind: expected %0d, got %0d", e.kind, out_data.kind);
            errs++;
          end
          if (out_data.payload !== e.payload) begin
            $error("payload: expected %0d, got %0d", e.payload, out_data.payload);
            errs++;
          end
          if (out_data.frame_first !== e.frame_first) begin
            $error("frame_first: expected %0d, got %0d", e.frame_first, out_data.frame_first);
            errs++;
          end
          if (out_data.frame_last !== e.frame_last) begin
            $error("frame_last: expected %0d, got %0d", e.frame_last, out_data.frame_last);
            errs++;
          end
          if (out_data.frame_time !== e.frame_time) begin
            $error("frame_time: expected %0d, got %0d", e.frame_time, out_data.frame_time);
            errs++;
          end
          if (out_data.fault !== e.fault) begin
            $error("fault: expected %0d, got %0d", e.fault, out_data.fault);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) deframe_byte(in_data);
    end
    fails   <= errs;
    pending <= awaited_out.size();
  end

endmodule

[bench/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import adts_dfr_pkg::*;

  localparam logic [2:0] RATE_ADDR   = 3'd0;
  localparam int         CYCLE_LIMIT = 400000;
  localparam int         DRAIN_WAIT  = 60;
  localparam int         ITEM_GOAL   = 850;
  localparam int         PHASES      = 7;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int          fails;
  int          pending;
  int          cycle_cnt = 0;
  int          sent      = 0;
  bit          steady    = 1'b0;
  logic [7:0]  pes_q[$];

  adts_aac_frame_deframer_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  adts_frame_checker #(.RATE_ADDR(RATE_ADDR)) u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .fails    (fails),
    .pending  (pending)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Stall the result side at random unless a steady stretch is running
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= 10);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [PTS_W-1:0] rand_pts();
    return PTS_W'({$urandom, $urandom});
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_byte(logic [7:0] b, logic s, logic e, logic [PTS_W-1:0] pts);
    in_item_t it;
    it.data_byte = b;
    it.pes_start = s;
    it.pes_end   = e;
    it.pes_pts   = pts;
    while (!steady && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
  endtask

  // Append one ADTS frame: header with the given length field, then body bytes
  task automatic add_frame(bit crc, int body, int len);
    logic [12:0] lf;
    lf = 13'(len);
    pes_q.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'hFF);
    pes_q.push_back({7'($urandom), ~crc});
    pes_q.push_back(8'($urandom));
    pes_q.push_back({6'($urandom), lf[12:11]});
    pes_q.push_back(lf[10:3]);
    pes_q.push_back({lf[2:0], 5'($urandom)});
    pes_q.push_back(8'($urandom));
    if (crc) begin
      pes_q.push_back(8'($urandom));
      pes_q.push_back(8'($urandom));
    end
    repeat (body) pes_q.push_back(8'($urandom));
  endtask

  // Send the built PES, marking the first byte and optionally the last
  task automatic send_pes(logic [PTS_W-1:0] pts, bit with_end);
    int n;
    n = pes_q.size();
    for (int i = 0; i < n; i++) begin
      send_byte(pes_q[i], i == 0, with_end && (i == n - 1), (i == 0) ? pts : rand_pts());
    end
    pes_q.delete();
  endtask

  // Build one PES: mostly well-formed, some cut, bad or noisy
  task automatic random_pes();
    int  r;
    int  nfr;
    int  body;
    int  hl;
    int  len;
    int  first_hl;
    bit  crc;
    r        = $urandom_range(99);
    nfr      = $urandom_range(4, 1);
    first_hl = 7;
    for (int f = 0; f < nfr; f++) begin
      crc  = 1'($urandom_range(1, 0));
      hl   = crc ? 9 : 7;
      body = ($urandom_range(9) == 0) ? $urandom_range(60, 13) : $urandom_range(12, 0);
      len  = hl + body;
      if (f == 0) first_hl = hl;
      if (r >= 70 && r < 80 && f == nfr - 1) len = $urandom_range(hl - 1, 0);
      add_frame(crc, body, len);
    end
    if (r < 65 || (r >= 70 && r < 80)) begin
      send_pes(rand_pts(), 1'b1);
    end else if (r < 70) begin
      // Leave the PES open; the next start abandons any open frame
      if (pes_q.size() > 1) pes_q = pes_q[0:$urandom_range(pes_q.size() - 1, 1) - 1];
      send_pes(rand_pts(), 1'b0);
    end else if (r < 85) begin
      // End the PES right where the first header completes
      pes_q = pes_q[0:first_hl - 1];
      send_pes(rand_pts(), 1'b1);
    end else if (r < 95) begin
      if (pes_q.size() > 1) pes_q = pes_q[0:$urandom_range(pes_q.size() - 1, 1) - 1];
      send_pes(rand_pts(), 1'b1);
    end else begin
      pes_q.delete();
      repeat ($urandom_range(10, 1)) begin
        send_byte(8'($urandom), $urandom_range(7) == 0, $urandom_range(7) == 0, rand_pts());
      end
    end
  endtask

  // Drop valid and wait until every expected result is out and the block is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the write lands on the access edge
  task automatic write_rate(logic [31:0] v);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= RATE_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int rate_plan[PHASES];
    int target;
    rate_plan = '{7350, 96000, 0, 131071, 1, 44100, 0};
    rate_plan[PHASES - 1] = $urandom_range(96000, 7350);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a one-byte frame, then a header-only frame with CRC, no end mark
    add_frame(1'b0, 1, 8);
    pes_q[7] = 8'h00;
    add_frame(1'b1, 0, 9);
    send_pes('0, 1'b0);
    // Maximum length field cut short by the end of the PES
    add_frame(1'b0, 1, 8191);
    send_pes({PTS_W{1'b1}}, 1'b1);
    // Start and end on the same byte: truncated header
    send_byte(8'hFF, 1'b1, 1'b1, rand_pts());

    // Random phases, one sample rate each
    target = sent;
    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_rate(32'(rate_plan[p]));
      steady = (p == 2);
      target += ITEM_GOAL / PHASES;
      while (sent < target) random_pes();
    end
    steady = 1'b0;

    settle();
    if (fails == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
